[rtl/ssp_pkg.sv]
// ----------------------------------------------------------------------------
// ssp_pkg
// Shared types, widths and helpers for the shortest-path engine.
// ----------------------------------------------------------------------------
`default_nettype none

package ssp_pkg;

  localparam int VERTEX_W = 6;
  localparam int COUNT_W  = 7;
  localparam int WEIGHT_W = 16;
  localparam int DIST_W   = 32;

  localparam int DEF_MAX_VERTICES = 64;
  localparam int DEF_MAX_EDGES    = 256;

  // Configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 7;
  localparam logic [CFG_IDX_W-1:0] CFG_VERTEX_COUNT  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_VERTEX = 1'b1;

  localparam logic [COUNT_W-1:0] VERTEX_COUNT_RST = 7'd1;

  localparam logic signed [DIST_W-1:0] DIST_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [DIST_W-1:0] DIST_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic [VERTEX_W-1:0]        src;
    logic [VERTEX_W-1:0]        dst;
    logic signed [WEIGHT_W-1:0] weight;
  } edge_t;

  // Distance plus weight, clamped to the signed 32-bit range
  function automatic logic signed [DIST_W-1:0] sat_add(
    input logic signed [DIST_W-1:0]   a,
    input logic signed [WEIGHT_W-1:0] b
  );
    logic signed [DIST_W:0] s;
    s = {a[DIST_W-1], a} + {{(DIST_W-WEIGHT_W+1){b[WEIGHT_W-1]}}, b};
    if (s[DIST_W] != s[DIST_W-1]) begin
      sat_add = s[DIST_W] ? DIST_MIN : DIST_MAX;
    end else begin
      sat_add = s[DIST_W-1:0];
    end
  endfunction

endpackage

`default_nettype wire

[rtl/ssp_ram.sv]
// ----------------------------------------------------------------------------
// ssp_ram
// Generic RAM: one write port, two read ports with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ssp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             re_a,
  input  wire logic [AW-1:0]    rd_addr_a,
  output logic      [WIDTH-1:0] rd_data_a,
  input  wire logic             re_b,
  input  wire logic [AW-1:0]    rd_addr_b,
  output logic      [WIDTH-1:0] rd_data_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    if (re_a) begin
      rd_data_a <= mem[rd_addr_a];
    end
    if (re_b) begin
      rd_data_b <= mem[rd_addr_b];
    end
  end

endmodule

`default_nettype wire

[rtl/single_source_shortest_paths.sv]
// ----------------------------------------------------------------------------
// single_source_shortest_paths
// Bellman-Ford shortest paths over an edge list held in on-chip RAM.
// ----------------------------------------------------------------------------
// Usage:
//   Configure vertex_count and source_vertex through cfg_we/cfg_index/
//   cfg_data while busy is low. Each edge is one transaction: start high
//   while busy is low loads edge_from/edge_to/edge_weight into the edge RAM
//   (one edge per cycle). Edges beyond MAX_EDGES are dropped. A transaction
//   with edge_last set starts the run and raises busy.
//   Run: the S_INIT state, then nv-1 relaxation passes and one cycle-check
//   pass over the E stored edges. Each edge goes through S_DREAD (the
//   edge RAM read feeds the distance RAM read) and S_RELAX (compare and
//   write-back); edges are processed one at a time through the single
//   read/modify/write path into the distance RAM.
//   Output: one result per vertex 0..nv-1, marked by result_valid for one
//   cycle in S_OEMIT, after a read in S_OREAD; result_last flags the
//   highest vertex. The receiver cannot stall; busy drops after the last
//   result and the edge store is empty again.
//   Reset (rst, synchronous) returns to idle with an empty edge store,
//   vertex_count 1 and source_vertex 0.
// ----------------------------------------------------------------------------
`default_nettype none

module single_source_shortest_paths #(
  parameter int MAX_VERTICES = ssp_pkg::DEF_MAX_VERTICES,
  parameter int MAX_EDGES    = ssp_pkg::DEF_MAX_EDGES
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  // configuration
  input  wire logic                                cfg_we,
  input  wire logic [ssp_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [ssp_pkg::CFG_DATA_W-1:0]      cfg_data,
  // edge input
  input  wire logic                                start,
  output logic                                     busy,
  input  wire logic [ssp_pkg::VERTEX_W-1:0]        edge_from,
  input  wire logic [ssp_pkg::VERTEX_W-1:0]        edge_to,
  input  wire logic signed [ssp_pkg::WEIGHT_W-1:0] edge_weight,
  input  wire logic                                edge_last,
  // results
  output logic                                     result_valid,
  output logic [ssp_pkg::VERTEX_W-1:0]             vertex_index,
  output logic signed [ssp_pkg::DIST_W-1:0]        distance,
  output logic                                     reachable,
  output logic                                     negative_cycle,
  output logic                                     result_last
);

  localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int ECW = $clog2(MAX_EDGES + 1);
  localparam int DAW = $clog2(MAX_VERTICES);
  localparam int CW  = ssp_pkg::COUNT_W;

  // Sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_INIT  = 3'd1;
  localparam logic [2:0] S_DREAD = 3'd2;
  localparam logic [2:0] S_RELAX = 3'd3;
  localparam logic [2:0] S_OREAD = 3'd4;
  localparam logic [2:0] S_OEMIT = 3'd5;

  logic [2:0] state;

  // configuration registers
  logic [CW-1:0]                vertex_count;
  logic [ssp_pkg::VERTEX_W-1:0] source_vertex;

  // run control
  logic [ECW-1:0]               edge_count;
  logic [EAW-1:0]               k;
  logic [CW-1:0]                nv;
  logic [CW-1:0]                pass_left;
  logic                         check;
  logic [ssp_pkg::VERTEX_W-1:0] vidx;
  logic [MAX_VERTICES-1:0]      reached;
  logic                         cycle_flag;

  logic accept;
  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;

  // Clamp vertex count into 1..MAX_VERTICES
  logic [CW-1:0] nv_sat;
  always_comb begin
    if (vertex_count == '0) begin
      nv_sat = CW'(1);
    end else if (vertex_count > CW'(MAX_VERTICES)) begin
      nv_sat = CW'(MAX_VERTICES);
    end else begin
      nv_sat = vertex_count;
    end
  end

  logic src_ok;
  assign src_ok = ({1'b0, source_vertex} < nv_sat);

  // ---------------------------------------------------------------------
  // Edge RAM: written while loading, read one edge ahead during the run
  // ---------------------------------------------------------------------
  ssp_pkg::edge_t edge_wr, edge_rd;
  logic           edge_we;
  logic           edge_re;
  logic [EAW-1:0] edge_rd_addr;
  logic           last_edge;

  assign edge_wr = '{src: edge_from, dst: edge_to, weight: edge_weight};
  assign edge_we = accept && (edge_count < ECW'(MAX_EDGES));

  assign last_edge    = (ECW'(k) == (edge_count - ECW'(1)));
  assign edge_re      = (state == S_INIT) || (state == S_RELAX);
  assign edge_rd_addr = ((state == S_INIT) || last_edge) ? '0 : k + EAW'(1);

  ssp_ram #(
    .WIDTH ($bits(ssp_pkg::edge_t)),
    .DEPTH (MAX_EDGES)
  ) u_edge_ram (
    .clk       (clk),
    .we        (edge_we),
    .wr_addr   (edge_count[EAW-1:0]),
    .wr_data   (edge_wr),
    .re_a      (edge_re),
    .rd_addr_a (edge_rd_addr),
    .rd_data_a (edge_rd),
    .re_b      (1'b0),
    .rd_addr_b (edge_rd_addr),
    .rd_data_b ()
  );

  // ---------------------------------------------------------------------
  // Distance RAM: port a reads the tail, port b the head (or the vertex
  // being reported); write-back lands before the next edge's read.
  // ---------------------------------------------------------------------
  logic                             dist_we;
  logic [DAW-1:0]                   dist_wr_addr;
  logic signed [ssp_pkg::DIST_W-1:0] dist_wr_data;
  logic                             dist_re;
  logic [DAW-1:0]                   dist_addr_a, dist_addr_b;
  logic signed [ssp_pkg::DIST_W-1:0] dist_u, dist_v;

  logic [DAW-1:0] eu, ev;
  logic           in_range;
  logic signed [ssp_pkg::DIST_W-1:0] cand;
  logic           can_relax;

  assign eu       = edge_rd.src[DAW-1:0];
  assign ev       = edge_rd.dst[DAW-1:0];
  assign in_range = ({1'b0, edge_rd.src} < nv) && ({1'b0, edge_rd.dst} < nv);
  assign cand     = ssp_pkg::sat_add(dist_u, edge_rd.weight);
  assign can_relax = in_range && reached[eu] && !(reached[ev] && (cand >= dist_v));

  assign dist_re     = (state == S_DREAD) || (state == S_OREAD);
  assign dist_addr_a = eu;
  assign dist_addr_b = (state == S_OREAD) ? vidx[DAW-1:0] : ev;

  always_comb begin
    dist_we      = 1'b0;
    dist_wr_addr = ev;
    dist_wr_data = cand;
    if (state == S_INIT) begin
      dist_we      = src_ok;
      dist_wr_addr = source_vertex[DAW-1:0];
      dist_wr_data = '0;
    end else if (state == S_RELAX) begin
      dist_we = can_relax && !check;
    end
  end

  ssp_ram #(
    .WIDTH (ssp_pkg::DIST_W),
    .DEPTH (MAX_VERTICES)
  ) u_dist_ram (
    .clk       (clk),
    .we        (dist_we),
    .wr_addr   (dist_wr_addr),
    .wr_data   (dist_wr_data),
    .re_a      (dist_re),
    .rd_addr_a (dist_addr_a),
    .rd_data_a (dist_u),
    .re_b      (dist_re),
    .rd_addr_b (dist_addr_b),
    .rd_data_b (dist_v)
  );

  // ---------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      vertex_count  <= ssp_pkg::VERTEX_COUNT_RST;
      source_vertex <= '0;
      edge_count    <= '0;
      k             <= '0;
      nv            <= ssp_pkg::VERTEX_COUNT_RST;
      pass_left     <= '0;
      check         <= 1'b0;
      vidx          <= '0;
      reached       <= '0;
      cycle_flag    <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          ssp_pkg::CFG_VERTEX_COUNT:  vertex_count  <= cfg_data;
          ssp_pkg::CFG_SOURCE_VERTEX: source_vertex <= cfg_data[ssp_pkg::VERTEX_W-1:0];
          default: ;
        endcase
      end

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (edge_we) begin
              edge_count <= edge_count + ECW'(1);
            end
            if (edge_last) begin
              state <= S_INIT;
            end
          end
        end

        S_INIT: begin
          nv         <= nv_sat;
          pass_left  <= nv_sat - CW'(1);
          check      <= (nv_sat == CW'(1));
          k          <= '0;
          cycle_flag <= 1'b0;
          // only the source starts out reached
          reached    <= src_ok ? (MAX_VERTICES'(1) << source_vertex[DAW-1:0]) : '0;
          state      <= S_DREAD;
        end

        S_DREAD: begin
          state <= S_RELAX;
        end

        S_RELAX: begin
          if (can_relax) begin
            if (check) begin
              cycle_flag <= 1'b1;
            end else begin
              reached[ev] <= 1'b1;
            end
          end
          k <= edge_rd_addr;
          if (last_edge && check) begin
            vidx  <= '0;
            state <= S_OREAD;
          end else begin
            state <= S_DREAD;
            if (last_edge) begin
              if (pass_left == CW'(1)) begin
                check <= 1'b1;
              end else begin
                pass_left <= pass_left - CW'(1);
              end
            end
          end
        end

        S_OREAD: begin
          state <= S_OEMIT;
        end

        S_OEMIT: begin
          if (result_last) begin
            edge_count <= '0;
            state      <= S_IDLE;
          end else begin
            vidx  <= vidx + ssp_pkg::VERTEX_W'(1);
            state <= S_OREAD;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Result transaction, one per vertex, valid in S_OEMIT
  // ---------------------------------------------------------------------
  assign result_valid   = (state == S_OEMIT);
  assign vertex_index   = vidx;
  assign reachable      = reached[vidx[DAW-1:0]];
  assign distance       = reachable ? dist_v : '0;
  assign negative_cycle = cycle_flag;
  assign result_last    = ({1'b0, vidx} == (nv - CW'(1)));

endmodule

`default_nettype wire
